// File: rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Types and constants shared by the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

	// command kinds
	localparam logic [1:0] KIND_PUT   = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	// configuration register indexes
	localparam logic CFG_DEFAULT_ATTR = 1'b0;
	localparam logic CFG_ERROR_ATTR   = 1'b1;

	// register reset values
	localparam logic [7:0] DEFAULT_ATTR_RST = 8'd15;
	localparam logic [7:0] ERROR_ATTR_RST   = 8'd244;

	// character codes
	localparam logic [7:0] NEWLINE_CODE = 8'h0a;
	localparam logic [7:0] ERROR_MARK   = 8'h45;
	localparam logic [7:0] BLANK_CODE   = 8'h20;

	// input transaction
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] char_code;
		logic [7:0] attr;
		logic       use_cursor;
		logic [6:0] col;
		logic [4:0] row;
	} cmd_t;

	// result transaction
	typedef struct packed {
		logic [7:0] cell_char;
		logic [7:0] cell_attr;
		logic [6:0] cursor_col;
		logic [4:0] cursor_row;
		logic       position_error;
	} result_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_SCROLL,
		ST_FILL
	} state_t;

endpackage

// File: rtl/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

// File: rtl/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer
// Text console engine: a screen store of character/attribute cells with a
// cursor, put, read and clear commands.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its result appears
// on result for exactly one cycle with done high and cannot be held off.
// Put (including newline and the error mark) and unknown kinds return their
// result in the next cycle. A read on screen passes through the registered
// read of the screen memory and then the READ state before its result shows.
// Clear returns its result in the next cycle, then keeps busy high while it
// writes a blank into every cell, one cell per cycle. A put that runs past
// the last cell returns its result in the next cycle, then keeps busy high
// while the memory's read port and write port copy each row one up, cell by
// cell, and then zero the bottom row. After reset the block is busy while it
// zeroes the screen memory. Configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module text_console_writer #(
	parameter int SCREEN_COLS = 80,
	parameter int SCREEN_ROWS = 25
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  tcw_pkg::cmd_t     cmd,
	output logic              done,
	output tcw_pkg::result_t  result,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [7:0]        cfg_data
);

	localparam int CELL_COUNT = SCREEN_COLS * SCREEN_ROWS;
	localparam int ADDR_W     = $clog2(CELL_COUNT);
	localparam logic [ADDR_W-1:0] COLS_A     = ADDR_W'(SCREEN_COLS);
	localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELL_COUNT - 1);
	localparam logic [ADDR_W-1:0] LAST_COPY  = ADDR_W'(CELL_COUNT - SCREEN_COLS);
	localparam logic [ADDR_W-1:0] ONE_A      = ADDR_W'(1);
	localparam logic [7:0]        COLS_CMP   = 8'(SCREEN_COLS);
	localparam logic [6:0]        ROWS_CMP   = 7'(SCREEN_ROWS);
	localparam logic [4:0]        BOTTOM_ROW = 5'(SCREEN_ROWS - 1);

	tcw_pkg::state_t state_q, state_nx;

	logic [ADDR_W-1:0] cnt_q;
	logic [6:0]        cur_col_q;
	logic [4:0]        cur_row_q;
	logic [7:0]        dflt_attr_q;
	logic [7:0]        err_attr_q;
	logic [15:0]       fill_data_q;
	logic              copy_pend_s1;
	logic [ADDR_W-1:0] copy_addr_s1;
	logic              done_q;
	tcw_pkg::result_t  result_q;

	logic              accept;
	logic              bad_pos;
	logic [6:0]        tgt_col;
	logic [4:0]        tgt_row;
	logic [ADDR_W-1:0] tgt_addr;
	logic              is_newline;
	logic [7:0]        col_inc;
	logic [6:0]        row_inc;
	logic              wrap;
	logic              need_scroll;
	logic [6:0]        nx_col;
	logic [4:0]        nx_row;
	logic [7:0]        put_attr;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_wr_addr;
	logic [15:0]       ram_wr_data;
	logic [ADDR_W-1:0] ram_rd_addr;
	logic [15:0]       ram_rd_data;

	// screen memory
	tcw_ram #(
		.WIDTH(16),
		.DEPTH(CELL_COUNT)
	) u_screen (
		.clk    (clk),
		.we     (ram_we),
		.wr_addr(ram_wr_addr),
		.wr_data(ram_wr_data),
		.rd_addr(ram_rd_addr),
		.rd_data(ram_rd_data)
	);

	// command decode and target cell
	always_comb begin
		accept   = start && !busy;
		bad_pos  = !cmd.use_cursor &&
			(({1'b0, cmd.col} >= COLS_CMP) || ({2'b00, cmd.row} >= ROWS_CMP));
		tgt_col  = cmd.use_cursor ? cur_col_q : cmd.col;
		tgt_row  = cmd.use_cursor ? cur_row_q : cmd.row;
		tgt_addr = ADDR_W'(tgt_row) * COLS_A + ADDR_W'(tgt_col);
	end

	// cursor advance for a put
	always_comb begin
		is_newline  = (cmd.char_code == tcw_pkg::NEWLINE_CODE);
		col_inc     = {1'b0, tgt_col} + 8'd1;
		row_inc     = {2'b00, tgt_row} + 7'd1;
		wrap        = is_newline || (col_inc == COLS_CMP);
		need_scroll = wrap && (row_inc == ROWS_CMP);
		nx_col      = wrap ? 7'd0 : col_inc[6:0];
		if (need_scroll) begin
			nx_row = BOTTOM_ROW;
		end else if (wrap) begin
			nx_row = row_inc[4:0];
		end else begin
			nx_row = tgt_row;
		end
		put_attr = (cmd.attr == 8'd0) ? dflt_attr_q : cmd.attr;
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			tcw_pkg::ST_IDLE: begin
				if (accept) begin
					case (cmd.kind)
						tcw_pkg::KIND_PUT: begin
							if (!bad_pos && need_scroll) begin
								state_nx = tcw_pkg::ST_SCROLL;
							end
						end
						tcw_pkg::KIND_READ: begin
							if (!bad_pos) begin
								state_nx = tcw_pkg::ST_READ;
							end
						end
						tcw_pkg::KIND_CLEAR: state_nx = tcw_pkg::ST_FILL;
						default:             state_nx = tcw_pkg::ST_IDLE;
					endcase
				end
			end
			tcw_pkg::ST_READ: state_nx = tcw_pkg::ST_IDLE;
			tcw_pkg::ST_SCROLL: begin
				if (cnt_q == LAST_COPY) begin
					state_nx = tcw_pkg::ST_FILL;
				end
			end
			tcw_pkg::ST_FILL: begin
				if (cnt_q == LAST_CELL) begin
					state_nx = tcw_pkg::ST_IDLE;
				end
			end
			default: state_nx = tcw_pkg::ST_IDLE;
		endcase
	end

	// memory port control
	always_comb begin
		busy        = (state_q != tcw_pkg::ST_IDLE);
		ram_we      = 1'b0;
		ram_wr_addr = cnt_q;
		ram_wr_data = fill_data_q;
		ram_rd_addr = tgt_addr;
		if (state_q == tcw_pkg::ST_SCROLL) begin
			ram_rd_addr = cnt_q + COLS_A;
		end
		if (copy_pend_s1) begin
			ram_we      = 1'b1;
			ram_wr_addr = copy_addr_s1;
			ram_wr_data = ram_rd_data;
		end else if (state_q == tcw_pkg::ST_FILL) begin
			ram_we = 1'b1;
		end else if (accept && (cmd.kind == tcw_pkg::KIND_PUT)) begin
			if (bad_pos) begin
				ram_we      = 1'b1;
				ram_wr_addr = LAST_CELL;
				ram_wr_data = {err_attr_q, tcw_pkg::ERROR_MARK};
			end else if (!is_newline) begin
				ram_we      = 1'b1;
				ram_wr_addr = tgt_addr;
				ram_wr_data = {put_attr, cmd.char_code};
			end
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcw_pkg::ST_FILL;
		end else begin
			state_q <= state_nx;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dflt_attr_q <= tcw_pkg::DEFAULT_ATTR_RST;
			err_attr_q  <= tcw_pkg::ERROR_ATTR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				tcw_pkg::CFG_DEFAULT_ATTR: dflt_attr_q <= cfg_data;
				tcw_pkg::CFG_ERROR_ATTR:   err_attr_q  <= cfg_data;
				default:                   dflt_attr_q <= dflt_attr_q;
			endcase
		end
	end

	// sweep counter, fill value and row copy pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			fill_data_q  <= '0;
			copy_pend_s1 <= 1'b0;
			copy_addr_s1 <= '0;
		end else begin
			copy_pend_s1 <= 1'b0;
			copy_addr_s1 <= cnt_q;
			case (state_q)
				tcw_pkg::ST_IDLE: begin
					cnt_q <= '0;
					if (accept && (cmd.kind == tcw_pkg::KIND_CLEAR)) begin
						fill_data_q <= {dflt_attr_q, tcw_pkg::BLANK_CODE};
					end else begin
						fill_data_q <= '0;
					end
				end
				tcw_pkg::ST_SCROLL: begin
					if (cnt_q != LAST_COPY) begin
						copy_pend_s1 <= 1'b1;
						cnt_q        <= cnt_q + ONE_A;
					end
				end
				tcw_pkg::ST_FILL: cnt_q <= cnt_q + ONE_A;
				default:          cnt_q <= cnt_q;
			endcase
		end
	end

	// cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q <= '0;
			cur_row_q <= '0;
		end else if (accept) begin
			case (cmd.kind)
				tcw_pkg::KIND_PUT: begin
					if (!bad_pos) begin
						cur_col_q <= nx_col;
						cur_row_q <= nx_row;
					end
				end
				tcw_pkg::KIND_CLEAR: begin
					cur_col_q <= '0;
					cur_row_q <= '0;
				end
				default: cur_col_q <= cur_col_q;
			endcase
		end
	end

	// result transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == tcw_pkg::ST_READ) ||
				(accept && !((cmd.kind == tcw_pkg::KIND_READ) && !bad_pos));
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == tcw_pkg::ST_READ) begin
			result_q.cell_char      <= ram_rd_data[7:0];
			result_q.cell_attr      <= ram_rd_data[15:8];
			result_q.cursor_col     <= cur_col_q;
			result_q.cursor_row     <= cur_row_q;
			result_q.position_error <= 1'b0;
		end else if (accept) begin
			result_q.cell_char      <= '0;
			result_q.cell_attr      <= '0;
			result_q.cursor_col     <= cur_col_q;
			result_q.cursor_row     <= cur_row_q;
			result_q.position_error <= 1'b0;
			case (cmd.kind)
				tcw_pkg::KIND_PUT: begin
					result_q.position_error <= bad_pos;
					if (!bad_pos) begin
						result_q.cursor_col <= nx_col;
						result_q.cursor_row <= nx_row;
					end
				end
				tcw_pkg::KIND_READ: result_q.position_error <= bad_pos;
				tcw_pkg::KIND_CLEAR: begin
					result_q.cursor_col <= '0;
					result_q.cursor_row <= '0;
				end
				default: result_q.position_error <= 1'b0;
			endcase
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// File: dv/text_console_writer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_test
// Self-checking testbench for the text console writer. A queue of commands,
// directed first and then random typing runs mixed with noise, feeds a
// clocked driver. Every accepted transaction is run through a local model of
// the screen store, the cursor and the attribute registers. A clocked
// monitor compares each result transaction field by field with the oldest
// expected one. Attribute registers change between phases while idle.
// ----------------------------------------------------------------------------
module text_console_writer_test;

	localparam int COLS = 80;
	localparam int ROWS = 25;
	localparam int CELLS = COLS * ROWS;
	localparam int CYCLE_LIMIT = 4_000_000;
	localparam int PHASE_ITEMS = 100;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic             busy;
	tcw_pkg::cmd_t    cmd = '0;
	logic             done;
	tcw_pkg::result_t result;
	logic             cfg_we = 1'b0;
	logic             cfg_index = tcw_pkg::CFG_DEFAULT_ATTR;
	logic [7:0]       cfg_data = '0;

	// model of the console
	logic [15:0] screen_model [CELLS];
	int          cursor_model = 0;
	logic [7:0]  default_attr_model = tcw_pkg::DEFAULT_ATTR_RST;
	logic [7:0]  error_attr_model = tcw_pkg::ERROR_ATTR_RST;

	tcw_pkg::cmd_t    pending_cmds [$];
	tcw_pkg::result_t expected_results [$];
	int               error_count = 0;
	int               cycle_count = 0;
	int               gap_left = 0;
	logic             burst_mode = 1'b0;

	text_console_writer #(
		.SCREEN_COLS(COLS),
		.SCREEN_ROWS(ROWS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		for (int i = 0; i < CELLS; i++) screen_model[i] = '0;
	end

	// run one command on the console model and return its result
	function automatic tcw_pkg::result_t apply_command(tcw_pkg::cmd_t c);
		tcw_pkg::result_t r;
		int               pos;
		logic             bad;
		logic [7:0]       at;
		r = '0;
		bad = !c.use_cursor && (int'(c.col) >= COLS || int'(c.row) >= ROWS);
		pos = c.use_cursor ? cursor_model : int'(c.row) * COLS + int'(c.col);
		case (c.kind)
			tcw_pkg::KIND_PUT: begin
				if (bad) begin
					screen_model[CELLS - 1] = {error_attr_model, tcw_pkg::ERROR_MARK};
					r.position_error = 1'b1;
				end else begin
					at = (c.attr == '0) ? default_attr_model : c.attr;
					if (c.char_code == tcw_pkg::NEWLINE_CODE) begin
						pos = (pos / COLS + 1) * COLS;
					end else begin
						screen_model[pos] = {at, c.char_code};
						pos++;
					end
					// ran past the last cell: scroll everything up one row
					if (pos >= CELLS) begin
						for (int i = 0; i < CELLS - COLS; i++)
							screen_model[i] = screen_model[i + COLS];
						for (int i = CELLS - COLS; i < CELLS; i++)
							screen_model[i] = '0;
						pos -= COLS;
					end
					cursor_model = pos;
				end
			end
			tcw_pkg::KIND_READ: begin
				if (bad) begin
					r.position_error = 1'b1;
				end else begin
					r.cell_char = screen_model[pos][7:0];
					r.cell_attr = screen_model[pos][15:8];
				end
			end
			tcw_pkg::KIND_CLEAR: begin
				for (int i = 0; i < CELLS; i++)
					screen_model[i] = {default_attr_model, tcw_pkg::BLANK_CODE};
				cursor_model = 0;
			end
			default: begin
			end
		endcase
		r.cursor_col = 7'(cursor_model % COLS);
		r.cursor_row = 5'(cursor_model / COLS);
		return r;
	endfunction

	// idle length between transactions: mostly short, a few long
	function automatic int pick_gap();
		int sel;
		sel = $urandom_range(0, 99);
		if (burst_mode) return 0;
		if (sel < 45) return 0;
		if (sel < 85) return $urandom_range(1, 3);
		if (sel < 97) return $urandom_range(4, 20);
		return $urandom_range(40, 150);
	endfunction

	// driver: presents queued commands, predicts each accepted transaction
	always @(posedge clk) begin : drive_commands
		logic next_start;
		next_start = start;
		if (!arst_n) begin
			next_start = 1'b0;
		end else begin
			if (start && !busy) begin
				expected_results.push_back(apply_command(cmd));
				pending_cmds.delete(0);
				next_start = 1'b0;
				gap_left = pick_gap();
			end
			if (!next_start) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_cmds.size() != 0) begin
					next_start = 1'b1;
					cmd <= pending_cmds[0];
				end
			end
		end
		start <= next_start;
	end

	task automatic check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			error_count++;
		end
	endtask

	// monitor: every result transaction against the oldest expectation
	always @(posedge clk) begin : check_results
		tcw_pkg::result_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %p", $time, result);
				error_count++;
			end else begin
				want = expected_results.pop_front();
				check_field("cell_char", want.cell_char, result.cell_char);
				check_field("cell_attr", want.cell_attr, result.cell_attr);
				check_field("cursor_col", 8'(want.cursor_col), 8'(result.cursor_col));
				check_field("cursor_row", 8'(want.cursor_row), 8'(result.cursor_row));
				check_field("position_error", 8'(want.position_error),
					8'(result.position_error));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time,
				expected_results.size());
			$display("status: fail");
			$finish;
		end
	end

	function automatic tcw_pkg::cmd_t make_cmd(logic [1:0] kind, logic [7:0] ch,
			logic [7:0] at, logic uc, logic [6:0] col, logic [4:0] row);
		tcw_pkg::cmd_t c;
		c.kind = kind;
		c.char_code = ch;
		c.attr = at;
		c.use_cursor = uc;
		c.col = col;
		c.row = row;
		return c;
	endfunction

	task automatic wait_idle();
		do @(negedge clk);
		while (pending_cmds.size() != 0 || expected_results.size() != 0 || start || busy);
	endtask

	// write both attribute registers on back-to-back cycles
	task automatic set_attributes(input logic [7:0] def_attr, input logic [7:0] err_attr);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= tcw_pkg::CFG_DEFAULT_ATTR;
		cfg_data <= def_attr;
		@(posedge clk);
		cfg_index <= tcw_pkg::CFG_ERROR_ATTR;
		cfg_data <= err_attr;
		@(posedge clk);
		cfg_we <= 1'b0;
		default_attr_model = def_attr;
		error_attr_model = err_attr;
	endtask

	function automatic logic [7:0] random_attr();
		return ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
	endfunction

	function automatic logic [7:0] random_char();
		return ($urandom_range(0, 9) == 0) ? tcw_pkg::NEWLINE_CODE : 8'($urandom);
	endfunction

	// typing run: place a character, type on at the cursor, read back
	task automatic queue_typing_run();
		logic [6:0] col0;
		logic [4:0] row0;
		int         n;
		col0 = 7'($urandom_range(0, COLS - 1));
		row0 = ($urandom_range(0, 5) == 0) ? 5'(ROWS - 1) : 5'($urandom_range(0, ROWS - 1));
		n = $urandom_range(2, 12);
		pending_cmds.push_back(make_cmd(tcw_pkg::KIND_PUT, random_char(), random_attr(),
			1'b0, col0, row0));
		repeat (n) begin
			pending_cmds.push_back(make_cmd(tcw_pkg::KIND_PUT, random_char(), random_attr(),
				1'b1, 7'($urandom), 5'($urandom)));
		end
		pending_cmds.push_back(make_cmd(tcw_pkg::KIND_READ, 8'($urandom), 8'($urandom),
			1'b0, col0, row0));
		if ($urandom_range(0, 1) == 1)
			pending_cmds.push_back(make_cmd(tcw_pkg::KIND_READ, 8'($urandom), 8'($urandom),
				1'b1, 7'($urandom), 5'($urandom)));
	endtask

	// noise: any field values, positions sometimes off screen
	task automatic queue_noise();
		tcw_pkg::cmd_t c;
		int            sel;
		c = tcw_pkg::cmd_t'($urandom);
		sel = $urandom_range(0, 99);
		if (sel < 48) c.kind = tcw_pkg::KIND_PUT;
		else if (sel < 93) c.kind = tcw_pkg::KIND_READ;
		else if (sel < 96) c.kind = tcw_pkg::KIND_CLEAR;
		else c.kind = KIND_UNUSED;
		if ($urandom_range(0, 3) != 0) begin
			c.col = 7'($urandom_range(0, COLS - 1));
			c.row = 5'($urandom_range(0, ROWS - 1));
		end
		pending_cmds.push_back(c);
	endtask

	// stimulus and phase control
	initial begin : stimulus
		logic [7:0] def_list [5];
		logic [7:0] err_list [5];
		def_list = '{8'h00, 8'hff, 8'h00, 8'h80, 8'h01};
		err_list = '{8'hff, 8'h00, 8'h00, 8'h01, 8'h80};
		def_list[2] = 8'($urandom_range(1, 254));
		err_list[2] = 8'($urandom_range(1, 254));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part with the reset attributes
		pending_cmds.push_back(make_cmd(tcw_pkg::KIND_READ, 8'h00, 8'h00, 1'b0, 7'd0, 5'd0));
		pending_cmds.push_back(make_cmd(tcw_pkg::KIND_PUT, 8'h41, 8'h00, 1'b0, 7'd0, 5'd0));
		pending_cmds.push_back(make_cmd(tcw_pkg::KIND_READ, 8'h00, 8'h00, 1'b0, 7'd0, 5'd0));
		pending_cmds.push_back(make_cmd(tcw_pkg::KIND_PUT, 8'hff, 8'hff, 1'b1, 7'd0, 5'd0));
		pending_cmds.push_back(make_cmd(tcw_pkg::KIND_PUT, tcw_pkg::NEWLINE_CODE, 8'h00,
			1'b1, 7'd0, 5'd0));
		pending_cmds.push_back(make_cmd(tcw_pkg::KIND_PUT, 8'h78, 8'h33, 1'b0, 7'd127,
			5'd31));
		pending_cmds.push_back(make_cmd(tcw_pkg::KIND_READ, 8'h00, 8'h00, 1'b0, 7'd79,
			5'd24));
		pending_cmds.push_back(make_cmd(tcw_pkg::KIND_PUT, 8'h61, 8'h01, 1'b0, 7'd80, 5'd0));
		pending_cmds.push_back(make_cmd(tcw_pkg::KIND_PUT, 8'h62, 8'h01, 1'b0, 7'd0, 5'd25));
		pending_cmds.push_back(make_cmd(tcw_pkg::KIND_READ, 8'hff, 8'hff, 1'b0, 7'd127,
			5'd0));
		pending_cmds.push_back(make_cmd(tcw_pkg::KIND_READ, 8'hff, 8'hff, 1'b1, 7'd127,
			5'd31));
		pending_cmds.push_back(make_cmd(tcw_pkg::KIND_PUT, 8'h00, 8'h01, 1'b1, 7'd127,
			5'd31));
		pending_cmds.push_back(make_cmd(KIND_UNUSED, 8'hff, 8'hff, 1'b1, 7'd127, 5'd31));
		// last cell written: scroll
		pending_cmds.push_back(make_cmd(tcw_pkg::KIND_PUT, 8'h5a, 8'h00, 1'b0, 7'd79,
			5'd24));
		pending_cmds.push_back(make_cmd(tcw_pkg::KIND_READ, 8'h00, 8'h00, 1'b0, 7'd79,
			5'd23));
		pending_cmds.push_back(make_cmd(tcw_pkg::KIND_READ, 8'h00, 8'h00, 1'b0, 7'd0,
			5'd24));
		// newline on the bottom row: scroll
		pending_cmds.push_back(make_cmd(tcw_pkg::KIND_PUT, tcw_pkg::NEWLINE_CODE, 8'h00,
			1'b0, 7'd5, 5'd24));
		pending_cmds.push_back(make_cmd(tcw_pkg::KIND_READ, 8'h00, 8'h00, 1'b0, 7'd79,
			5'd22));
		pending_cmds.push_back(make_cmd(tcw_pkg::KIND_CLEAR, 8'hff, 8'hff, 1'b1, 7'd127,
			5'd31));
		pending_cmds.push_back(make_cmd(tcw_pkg::KIND_READ, 8'h00, 8'h00, 1'b0, 7'd40,
			5'd12));
		pending_cmds.push_back(make_cmd(tcw_pkg::KIND_READ, 8'h00, 8'h00, 1'b1, 7'd0, 5'd0));
		pending_cmds.push_back(make_cmd(tcw_pkg::KIND_PUT, 8'h71, 8'h80, 1'b0, 7'd79, 5'd0));
		pending_cmds.push_back(make_cmd(tcw_pkg::KIND_READ, 8'h00, 8'h00, 1'b1, 7'd0, 5'd0));
		pending_cmds.push_back(make_cmd(tcw_pkg::KIND_READ, 8'h00, 8'h00, 1'b0, 7'd79,
			5'd0));

		// random phases, each under its own attribute setting
		for (int phase = 0; phase < 5; phase++) begin
			wait_idle();
			set_attributes(def_list[phase], err_list[phase]);
			burst_mode = (phase == 2);
			while (pending_cmds.size() < PHASE_ITEMS) begin
				if ($urandom_range(0, 9) < 6) begin
					queue_typing_run();
				end else begin
					repeat ($urandom_range(1, 6)) queue_noise();
				end
			end
			@(negedge clk);
		end

		wait_idle();
		repeat (10) @(negedge clk);
		if (error_count == 0 && expected_results.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
